/* rtl/conv2d_point_engine_macros.svh */
// Assertion macros shared by the point engine RTL.
`ifndef CONV2D_POINT_ENGINE_MACROS_SVH
`define CONV2D_POINT_ENGINE_MACROS_SVH

// Check that expr holds in the same cycle as cond.
`define CPE_ASSERT_IMPLY(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that expr holds in the cycle after cond.
`define CPE_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* rtl/cpe_pkg.sv */
// Types and constants shared by the point engine modules.
package cpe_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int DATA_W     = 16;
	localparam int PROD_W     = 32;
	localparam int SUM_W      = 40;
	// signed image coordinate of a tap, covers out_row * stride + kernel
	localparam int POS_W      = 11;
	// unsigned width for the output map bound check
	localparam int CHK_W      = 12;
	// start value of the drain counter that waits after the last tap issue until the accumulator is final
	localparam logic [1:0] DRAIN_CYCLES = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE_WEIGHT = 2'd0,
		OP_WRITE_PIXEL  = 2'd1,
		OP_COMPUTE      = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_COUNT  = 3'd0,
		REG_KERNEL_HEIGHT = 3'd1,
		REG_KERNEL_WIDTH  = 3'd2,
		REG_CHANNEL_COUNT = 3'd3,
		REG_STEP_SIZE     = 3'd4,
		REG_PAD_WIDTH     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic idle;
		logic finish;
		logic bad;
		logic tap_use;
	} seq_stat_t;

endpackage

/* rtl/cpe_if.sv */
// Handshake channels of the point engine: request words in, result words out.
interface cpe_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [2:0]         filter_sel;
	logic [1:0]         channel_sel;
	logic [2:0]         kernel_row;
	logic [2:0]         kernel_col;
	logic [4:0]         pixel_row;
	logic [4:0]         pixel_col;
	logic [5:0]         out_row;
	logic [5:0]         out_col;
	logic signed [15:0] data_value;

	modport source (
		output valid, opcode, filter_sel, channel_sel, kernel_row, kernel_col,
		output pixel_row, pixel_col, out_row, out_col, data_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, filter_sel, channel_sel, kernel_row, kernel_col,
		input  pixel_row, pixel_col, out_row, out_col, data_value,
		output ready
	);
endinterface

interface cpe_result_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] conv_sum;
	logic [2:0]         result_filter;
	logic [5:0]         result_row;
	logic [5:0]         result_col;
	logic               status;

	modport source (
		output valid, conv_sum, result_filter, result_row, result_col, status,
		input  ready
	);
	modport sink (
		input  valid, conv_sum, result_filter, result_row, result_col, status,
		output ready
	);
endinterface

/* rtl/cpe_ram.sv */
// Generic simple dual-port RAM with registered read data.
module cpe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one word, read one word, both at the clock edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/cpe_mac.sv */
// Shared multiply-accumulate unit: one product and one 40-bit add per cycle.
module cpe_mac import cpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    use_s1,
	input  logic signed [DATA_W-1:0] weight,
	input  logic signed [DATA_W-1:0] pixel,
	output logic signed [SUM_W-1:0]  acc
);

	logic                      use_s2;
	logic                      use_s3;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [SUM_W-1:0]   acc_q;

	// track which memory reads belong to taps inside the image and sum their products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_s2 <= 1'b0;
			use_s3 <= 1'b0;
			acc_q  <= '0;
		end else begin
			use_s2 <= use_s1;
			use_s3 <= use_s2;
			if (clear) begin
				acc_q <= '0;
			end else if (use_s3) begin
				acc_q <= acc_q + SUM_W'(prod_s3);
			end
		end
	end

	// register the exact Q3.28 product
	always_ff @(posedge clk) begin
		prod_s3 <= weight * pixel;
	end

	assign acc = acc_q;

endmodule

/* rtl/cpe_seq.sv */
// Tap sequencer: checks a request, then walks channels and kernel taps.
module cpe_seq import cpe_pkg::*; #(
	parameter int MAX_FILTERS  = 8,
	parameter int MAX_CHANNELS = 4,
	parameter int MAX_KERNEL   = 7,
	parameter int IMAGE_ROWS   = 28,
	parameter int IMAGE_COLS   = 28,
	parameter int MAX_PADDING  = 3,
	localparam int NFW    = $clog2(MAX_FILTERS + 1),
	localparam int KB     = $clog2(MAX_KERNEL + 1),
	localparam int CB     = $clog2(MAX_CHANNELS + 1),
	localparam int PB     = (MAX_PADDING > 0) ? $clog2(MAX_PADDING + 1) : 1,
	localparam int WDEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS,
	localparam int PDEPTH = MAX_CHANNELS * IMAGE_ROWS * IMAGE_COLS,
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
	localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           out_free,
	input  logic [2:0]     filter_sel,
	input  logic [5:0]     out_row,
	input  logic [5:0]     out_col,
	input  logic [NFW-1:0] nf,
	input  logic [KB-1:0]  kh,
	input  logic [KB-1:0]  kw,
	input  logic [CB-1:0]  nc,
	input  logic [2:0]     step,
	input  logic [PB-1:0]  pad,
	output seq_stat_t      stat,
	output logic [WAW-1:0] waddr_s1,
	output logic [PAW-1:0] paddr_s1
);

	state_t                   state_q;
	state_t                   state_d;
	logic [CB-1:0]            c_q;
	logic [KB-1:0]            r_q;
	logic [KB-1:0]            q_q;
	logic signed [POS_W-1:0]  brow_q;
	logic signed [POS_W-1:0]  bcol_q;
	logic                     bad_q;
	logic [1:0]               drain_q;
	logic                     use_s1;

	logic [CHK_W-1:0]         row_end;
	logic [CHK_W-1:0]         col_end;
	logic [CHK_W-1:0]         row_lim;
	logic [CHK_W-1:0]         col_lim;
	logic                     req_ok;
	logic signed [POS_W-1:0]  brow_d;
	logic signed [POS_W-1:0]  bcol_d;
	logic signed [POS_W-1:0]  ir;
	logic signed [POS_W-1:0]  ic;
	logic                     inb;
	logic                     last_q;
	logic                     last_r;
	logic                     last_c;
	logic [WAW-1:0]           wa_d;
	logic [PAW-1:0]           pa_d;

	// check the request filter and output map: out * stride + kernel <= image + 2 * pad
	always_comb begin
		row_end = CHK_W'(out_row) * CHK_W'(step) + CHK_W'(kh);
		col_end = CHK_W'(out_col) * CHK_W'(step) + CHK_W'(kw);
		row_lim = CHK_W'(IMAGE_ROWS) + CHK_W'({pad, 1'b0});
		col_lim = CHK_W'(IMAGE_COLS) + CHK_W'({pad, 1'b0});
		req_ok  = (int'(filter_sel) < int'(nf)) && (row_end <= row_lim)
			&& (col_end <= col_lim);
		brow_d  = $signed(POS_W'(out_row) * POS_W'(step)) - $signed(POS_W'(pad));
		bcol_d  = $signed(POS_W'(out_col) * POS_W'(step)) - $signed(POS_W'(pad));
	end

	// form the image position and memory addresses of the current tap
	always_comb begin
		ir     = brow_q + $signed(POS_W'(r_q));
		ic     = bcol_q + $signed(POS_W'(q_q));
		inb    = (int'(ir) >= 0) && (int'(ir) < IMAGE_ROWS)
			&& (int'(ic) >= 0) && (int'(ic) < IMAGE_COLS);
		pa_d   = PAW'((int'(c_q) * IMAGE_ROWS + int'(ir)) * IMAGE_COLS + int'(ic));
		wa_d   = WAW'(((int'(filter_sel) * MAX_KERNEL + int'(r_q)) * MAX_KERNEL
			+ int'(q_q)) * MAX_CHANNELS + int'(c_q));
		last_q = (int'(q_q) + 1) == int'(kw);
		last_r = (int'(r_q) + 1) == int'(kh);
		last_c = (int'(c_q) + 1) == int'(nc);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = req_ok ? ST_RUN : ST_FINISH;
			end
			ST_RUN: begin
				if (last_q && last_r && last_c) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q == '0) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// status toward the top level
	always_comb begin
		stat.idle    = (state_q == ST_IDLE);
		stat.finish  = (state_q == ST_FINISH);
		stat.bad     = bad_q;
		stat.tap_use = use_s1;
	end

	// hold state, counters and request geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			r_q     <= '0;
			q_q     <= '0;
			bad_q   <= 1'b0;
			drain_q <= '0;
			use_s1  <= 1'b0;
			brow_q  <= '0;
			bcol_q  <= '0;
		end else begin
			state_q <= state_d;
			use_s1  <= (state_q == ST_RUN) && inb;
			case (state_q)
				ST_CHECK: begin
					bad_q  <= !req_ok;
					brow_q <= brow_d;
					bcol_q <= bcol_d;
					c_q    <= '0;
					r_q    <= '0;
					q_q    <= '0;
				end
				ST_RUN: begin
					// advance column, then row, then channel
					if (last_q) begin
						q_q <= '0;
						if (last_r) begin
							r_q <= '0;
							c_q <= c_q + 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						q_q <= q_q + 1'b1;
					end
					drain_q <= DRAIN_CYCLES;
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// register the read addresses of the issued tap
	always_ff @(posedge clk) begin
		waddr_s1 <= wa_d;
		paddr_s1 <= pa_d;
	end

endmodule

/* rtl/conv2d_point_engine.sv */
// Top level of the multichannel 2-D convolution point engine.
//
// Usage: request words arrive on item (valid/ready). Opcode write weight
// and write pixel store one 16-bit Q1.14 value and are taken one per cycle
// while the engine is idle; they produce no result. Opcode compute asks for
// one output point of one filter and yields one result word on result
// (valid/ready). The user must write the configuration registers over
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// A compute word walks N = channels * kernel rows * kernel columns taps
// (1 to 196 at the default sizes), one multiply-accumulate per cycle in
// the shared MAC; the sum passes the address, memory read, product and
// accumulator registers, and item is ready again in the same cycle as the
// result turns valid. A request outside the output map or filter count
// answers with status 1 and a zero sum.
// Reset clears the registers to their defaults and the control state; the
// weight and pixel memories are not cleared and must be written before use.
// When the receiver stalls, the finished result waits in the output
// register; store writes are still taken, and the next compute word is
// taken but holds in the final step until the result slot frees.
`include "conv2d_point_engine_macros.svh"

module conv2d_point_engine import cpe_pkg::*; #(
	parameter int MAX_FILTERS  = 8,
	parameter int MAX_CHANNELS = 4,
	parameter int MAX_KERNEL   = 7,
	parameter int IMAGE_ROWS   = 28,
	parameter int IMAGE_COLS   = 28,
	parameter int MAX_PADDING  = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cpe_item_if.sink              item,
	cpe_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NFW    = $clog2(MAX_FILTERS + 1);
	localparam int KB     = $clog2(MAX_KERNEL + 1);
	localparam int CB     = $clog2(MAX_CHANNELS + 1);
	localparam int PB     = (MAX_PADDING > 0) ? $clog2(MAX_PADDING + 1) : 1;
	localparam int WDEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
	localparam int PDEPTH = MAX_CHANNELS * IMAGE_ROWS * IMAGE_COLS;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
	localparam logic [KB-1:0] K_RST = KB'((MAX_KERNEL < 3) ? MAX_KERNEL : 3);

	// effective register values, already clamped
	logic [NFW-1:0]  nf_q;
	logic [KB-1:0]   kh_q;
	logic [KB-1:0]   kw_q;
	logic [CB-1:0]   nc_q;
	logic [2:0]      step_q;
	logic [PB-1:0]   pad_q;
	logic [NFW-1:0]  nf_d;
	logic [KB-1:0]   kh_d;
	logic [KB-1:0]   kw_d;
	logic [CB-1:0]   nc_d;
	logic [2:0]      step_d;
	logic [PB-1:0]   pad_d;

	logic            item_acc;
	op_t             op;
	logic            start;
	logic            w_we;
	logic            p_we;
	logic [WAW-1:0]  w_waddr;
	logic [PAW-1:0]  p_waddr;

	logic [2:0]      filt_q;
	logic [5:0]      orow_q;
	logic [5:0]      ocol_q;

	seq_stat_t       stat;
	logic [WAW-1:0]  w_raddr;
	logic [PAW-1:0]  p_raddr;
	logic [DATA_W-1:0] w_rdata;
	logic [DATA_W-1:0] p_rdata;
	logic signed [SUM_W-1:0] acc;

	logic                    res_free;
	logic                    res_load;
	logic                    res_valid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [2:0]              rfilt_q;
	logic [5:0]              rrow_q;
	logic [5:0]              rcol_q;
	logic                    status_q;

	// clamp register writes to the supported ranges
	always_comb begin
		nf_d   = (int'(cfg_data) > MAX_FILTERS) ? NFW'(MAX_FILTERS) : NFW'(cfg_data);
		kh_d   = (cfg_data[2:0] == 3'd0) ? KB'(1)
			: (int'(cfg_data[2:0]) > MAX_KERNEL) ? KB'(MAX_KERNEL) : KB'(cfg_data[2:0]);
		kw_d   = kh_d;
		nc_d   = (cfg_data[2:0] == 3'd0) ? CB'(1)
			: (int'(cfg_data[2:0]) > MAX_CHANNELS) ? CB'(MAX_CHANNELS)
			: CB'(cfg_data[2:0]);
		step_d = (cfg_data[2:0] == 3'd0) ? 3'd1 : cfg_data[2:0];
		pad_d  = (int'(cfg_data[1:0]) > MAX_PADDING) ? PB'(MAX_PADDING)
			: PB'(cfg_data[1:0]);
	end

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q   <= NFW'(1);
			kh_q   <= K_RST;
			kw_q   <= K_RST;
			nc_q   <= CB'(1);
			step_q <= 3'd1;
			pad_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FILTER_COUNT:  nf_q   <= nf_d;
				REG_KERNEL_HEIGHT: kh_q   <= kh_d;
				REG_KERNEL_WIDTH:  kw_q   <= kw_d;
				REG_CHANNEL_COUNT: nc_q   <= nc_d;
				REG_STEP_SIZE:     step_q <= step_d;
				REG_PAD_WIDTH:     pad_q  <= pad_d;
				default: begin
				end
			endcase
		end
	end

	// decode an accepted request word
	assign item.ready = stat.idle;
	assign item_acc   = item.valid && item.ready;
	assign op         = op_t'(item.opcode);

	always_comb begin
		start   = 1'b0;
		w_we    = 1'b0;
		p_we    = 1'b0;
		w_waddr = WAW'(((int'(item.filter_sel) * MAX_KERNEL + int'(item.kernel_row))
			* MAX_KERNEL + int'(item.kernel_col)) * MAX_CHANNELS + int'(item.channel_sel));
		p_waddr = PAW'((int'(item.channel_sel) * IMAGE_ROWS + int'(item.pixel_row))
			* IMAGE_COLS + int'(item.pixel_col));
		case (op)
			OP_WRITE_WEIGHT: begin
				// drop writes outside the weight store
				w_we = item_acc && (int'(item.filter_sel) < MAX_FILTERS)
					&& (int'(item.channel_sel) < MAX_CHANNELS)
					&& (int'(item.kernel_row) < MAX_KERNEL)
					&& (int'(item.kernel_col) < MAX_KERNEL);
			end
			OP_WRITE_PIXEL: begin
				// drop writes outside the image
				p_we = item_acc && (int'(item.channel_sel) < MAX_CHANNELS)
					&& (int'(item.pixel_row) < IMAGE_ROWS)
					&& (int'(item.pixel_col) < IMAGE_COLS);
			end
			OP_COMPUTE: begin
				start = item_acc;
			end
			default: begin
			end
		endcase
	end

	// capture the request of a compute word
	always_ff @(posedge clk) begin
		if (start) begin
			filt_q <= item.filter_sel;
			orow_q <= item.out_row;
			ocol_q <= item.out_col;
		end
	end

	cpe_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (item.data_value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	cpe_ram #(.WIDTH(DATA_W), .DEPTH(PDEPTH)) u_pixel_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (item.data_value),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	cpe_seq #(
		.MAX_FILTERS  (MAX_FILTERS),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_KERNEL   (MAX_KERNEL),
		.IMAGE_ROWS   (IMAGE_ROWS),
		.IMAGE_COLS   (IMAGE_COLS),
		.MAX_PADDING  (MAX_PADDING)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.out_free   (res_free),
		.filter_sel (filt_q),
		.out_row    (orow_q),
		.out_col    (ocol_q),
		.nf         (nf_q),
		.kh         (kh_q),
		.kw         (kw_q),
		.nc         (nc_q),
		.step       (step_q),
		.pad        (pad_q),
		.stat       (stat),
		.waddr_s1   (w_raddr),
		.paddr_s1   (p_raddr)
	);

	cpe_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (start),
		.use_s1 (stat.tap_use),
		.weight (w_rdata),
		.pixel  (p_rdata),
		.acc    (acc)
	);

	// load the result slot when the sequencer finishes and the slot is free
	assign res_free = !res_valid_q || result.ready;
	assign res_load = stat.finish && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			sum_q    <= stat.bad ? '0 : acc;
			status_q <= stat.bad;
			rfilt_q  <= filt_q;
			rrow_q   <= orow_q;
			rcol_q   <= ocol_q;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.conv_sum      = sum_q;
	assign result.result_filter = rfilt_q;
	assign result.result_row    = rrow_q;
	assign result.result_col    = rcol_q;
	assign result.status        = status_q;

	`CPE_ASSERT_IMPLY(a_no_store_write_busy, !stat.idle, !(w_we || p_we), "store written while busy")
	`CPE_ASSERT_IMPLY(a_bad_sum_zero, result.valid && result.status, result.conv_sum == '0, "bad request with nonzero sum")
	`CPE_ASSERT_NEXT(a_result_loaded, stat.finish && res_free, result.valid && !stat.finish, "result not loaded on finish")

endmodule
